// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files; only the mapper top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post)
`define ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ===== src/ldpm_pkg.sv =====
// Types, constants and saturating helpers for the lens distortion point mapper.
package ldpm_pkg;

	localparam int FRAC    = 28;          // fraction bits of internal values
	localparam int IW      = 48;          // internal signed width
	localparam int QW      = IW - 1;      // magnitude width
	localparam int FW      = 32;          // focal / principal point component width
	localparam int MUL_LAT = 4;
	localparam int DIV_LAT = QW + 2;

	typedef logic signed [IW-1:0] fix_t;

	typedef struct packed {
		logic sat;
		fix_t val;
	} fix_sat_t;

	localparam fix_t LIM = 48'sh7FFF_FFFF_FFFF;
	localparam fix_t ONE_Q = 48'sh0000_1000_0000;
	localparam logic signed [IW:0] LIM_W = 49'sh0_7FFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		CFG_FOCAL_X,
		CFG_FOCAL_Y,
		CFG_PP,
		CFG_K1,
		CFG_K2,
		CFG_K3,
		CFG_P1,
		CFG_P2
	} cfg_idx_t;

	// a + b clipped to +-LIM
	function automatic fix_sat_t sadd(fix_t a, fix_t b);
		logic signed [IW:0] s;
		fix_sat_t r;
		s = $signed({a[IW-1], a}) + $signed({b[IW-1], b});
		r.sat = 1'b0;
		r.val = s[IW-1:0];
		if (s > LIM_W) begin
			r.sat = 1'b1;
			r.val = LIM;
		end else if (s < -LIM_W) begin
			r.sat = 1'b1;
			r.val = -LIM;
		end
		return r;
	endfunction

	function automatic fix_t sext32(logic [FW-1:0] v);
		return $signed({{(IW-FW){v[FW-1]}}, v});
	endfunction

	function automatic fix_t zext32(logic [FW-1:0] v);
		return $signed({{(IW-FW){1'b0}}, v});
	endfunction

endpackage

// ===== src/ldpm_ifs.sv =====
// Point and result stream interfaces.
interface ldpm_pt_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	modport source(output valid, point_x, point_y, input ready);
	modport sink(input valid, point_x, point_y, output ready);
endinterface

interface ldpm_res_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic saturated;
	modport source(output valid, out_x, out_y, saturated, input ready);
	modport sink(input valid, out_x, out_y, saturated, output ready);
endinterface

// ===== src/ldpm_dly.sv =====
// Stall-aware delay line for side values of the pipeline.
module ldpm_dly #(
	parameter int W = 48,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[N-1];

endmodule

// ===== src/ldpm_mul.sv =====
// Four-stage Q.28 multiplier: exact product, truncate toward zero, clip to +-LIM.
module ldpm_mul (
	input  logic             clk,
	input  logic             en,
	input  ldpm_pkg::fix_t   a,
	input  ldpm_pkg::fix_t   b,
	output ldpm_pkg::fix_sat_t y
);

	localparam int QW  = ldpm_pkg::QW;
	localparam int LO  = 24;
	localparam int HI  = QW - LO;
	localparam int PW  = 2 * QW;
	localparam int RLW = PW - ldpm_pkg::FRAC;

	logic [QW-1:0]      ma_s1, mb_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [2*LO-1:0]    ll_s2;
	logic [LO+HI-1:0]   m1_s2, m2_s2;
	logic [2*HI-1:0]    hh_s2;
	logic [PW-1:0]      p_s3;
	logic [RLW-1:0]     rl;
	logic               over;
	ldpm_pkg::fix_t     mv;

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= a[ldpm_pkg::IW-1] ? QW'(-a) : QW'(a);
			mb_s1  <= b[ldpm_pkg::IW-1] ? QW'(-b) : QW'(b);
			neg_s1 <= a[ldpm_pkg::IW-1] ^ b[ldpm_pkg::IW-1];

			ll_s2  <= ma_s1[LO-1:0] * mb_s1[LO-1:0];
			m1_s2  <= ma_s1[LO-1:0] * mb_s1[QW-1:LO];
			m2_s2  <= ma_s1[QW-1:LO] * mb_s1[LO-1:0];
			hh_s2  <= ma_s1[QW-1:LO] * mb_s1[QW-1:LO];
			neg_s2 <= neg_s1;

			p_s3   <= PW'(ll_s2) + (PW'(m1_s2) << LO) + (PW'(m2_s2) << LO)
				+ (PW'(hh_s2) << (2 * LO));
			neg_s3 <= neg_s2;

			y.sat  <= over;
			y.val  <= neg_s3 ? -mv : mv;
		end
	end

	always_comb begin
		rl   = p_s3[PW-1:ldpm_pkg::FRAC];
		over = rl > RLW'(ldpm_pkg::LIM);
		mv   = over ? ldpm_pkg::LIM : $signed(rl[ldpm_pkg::IW-1:0]);
	end

endmodule

// ===== src/ldpm_div.sv =====
// Pipelined restoring divider: (d << 28) / f, one quotient bit per stage.
module ldpm_div #(
	parameter int MW = 49
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [MW:0]          d,
	input  logic [ldpm_pkg::FW-1:0]     f,
	output ldpm_pkg::fix_sat_t          y
);

	localparam int QW   = ldpm_pkg::QW;
	localparam int FW   = ldpm_pkg::FW;
	localparam int SH   = QW - ldpm_pkg::FRAC;
	localparam int RW   = FW + 1;
	localparam int CMPW = (MW > FW + SH) ? MW : FW + SH;

	logic [FW-1:0] fe;
	logic [MW-1:0] m;
	logic [RW-1:0] r_s [QW];
	logic [QW-1:0] n_s [QW];
	logic [QW-1:0] q_s [QW+1];
	logic          neg_s [QW+1];
	logic          ovf_s [QW+1];
	ldpm_pkg::fix_t qv;

	// a zero focal length acts as one LSB
	assign fe = (f == '0) ? FW'(1) : f;
	assign m  = d[MW] ? MW'(-d) : MW'(d);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= RW'(m >> SH);
			n_s[0]   <= {m[SH-1:0], {ldpm_pkg::FRAC{1'b0}}};
			q_s[0]   <= '0;
			neg_s[0] <= d[MW];
			// quotient would need more than QW bits
			ovf_s[0] <= CMPW'(m) >= (CMPW'(fe) << SH);
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW-1:0] t;
		logic          ge;
		assign t  = {r_s[i][RW-2:0], n_s[i][QW-1]};
		assign ge = t >= {1'b0, fe};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1]   <= {q_s[i][QW-2:0], ge};
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end

		if (i < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[i+1] <= ge ? t - {1'b0, fe} : t;
					n_s[i+1] <= n_s[i] << 1;
				end
			end
		end
	end

	assign qv = ovf_s[QW] ? ldpm_pkg::LIM : $signed({1'b0, q_s[QW]});

	always_ff @(posedge clk) begin
		if (en) begin
			y.sat <= ovf_s[QW];
			y.val <= neg_s[QW] ? -qv : qv;
		end
	end

endmodule

// ===== src/lens_distortion_point_map.sv =====
// Top level of the five-coefficient lens distortion point mapper.
// Takes one pixel point (signed Q.16) per clock and returns the distorted point,
// fixed-point internals in signed Q.28 clipped to +-(2^47-1), with a saturated flag
// for any clipping. Throughput is one point per clock unless a result stalls; the pipe
// holds the 49-stage restoring divider that normalizes by the focal length and the six
// chained 4-stage multipliers. A stalled result freezes the whole pipeline; configure
// only while the pipe is empty.
`include "assert_macros.svh"

module lens_distortion_point_map #(
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	ldpm_pt_if.sink     pt,
	ldpm_res_if.source  res
);

	localparam int FW  = ldpm_pkg::FW;
	localparam int IW  = ldpm_pkg::IW;
	localparam int ML  = ldpm_pkg::MUL_LAT;
	localparam int DW  = ((COORD_WIDTH > FW) ? COORD_WIDTH : FW + 1) + 1;
	localparam int LAT = ldpm_pkg::DIV_LAT + 6 * ML + 6;
	localparam int OSW = IW + 2;
	localparam logic signed [OSW-1:0] CMAX = (OSW'(1) <<< (COORD_WIDTH - 1)) - OSW'(1);
	localparam logic signed [OSW-1:0] CMIN = -CMAX - OSW'(1);

	// configuration
	logic [FW-1:0] focal_x_q, focal_y_q, k1_q, k2_q, k3_q, p1_q, p2_q;
	logic [63:0]   pp_q;
	logic [FW-1:0] cx, cy;
	ldpm_pkg::fix_t k1, k2, k3, p1, p2, fx, fy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 32'd65536000;
			focal_y_q <= 32'd65536000;
			pp_q      <= '0;
			k1_q      <= '0;
			k2_q      <= '0;
			k3_q      <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
		end else if (cfg_we) begin
			case (ldpm_pkg::cfg_idx_t'(cfg_idx))
				ldpm_pkg::CFG_FOCAL_X: focal_x_q <= cfg_data[FW-1:0];
				ldpm_pkg::CFG_FOCAL_Y: focal_y_q <= cfg_data[FW-1:0];
				ldpm_pkg::CFG_PP:      pp_q      <= cfg_data;
				ldpm_pkg::CFG_K1:      k1_q      <= cfg_data[FW-1:0];
				ldpm_pkg::CFG_K2:      k2_q      <= cfg_data[FW-1:0];
				ldpm_pkg::CFG_K3:      k3_q      <= cfg_data[FW-1:0];
				ldpm_pkg::CFG_P1:      p1_q      <= cfg_data[FW-1:0];
				ldpm_pkg::CFG_P2:      p2_q      <= cfg_data[FW-1:0];
				default: ;
			endcase
		end
	end

	assign cx = pp_q[63:32];
	assign cy = pp_q[31:0];
	assign k1 = ldpm_pkg::sext32(k1_q);
	assign k2 = ldpm_pkg::sext32(k2_q);
	assign k3 = ldpm_pkg::sext32(k3_q);
	assign p1 = ldpm_pkg::sext32(p1_q);
	assign p2 = ldpm_pkg::sext32(p2_q);
	assign fx = ldpm_pkg::zext32(focal_x_q);
	assign fy = ldpm_pkg::zext32(focal_y_q);

	// pipeline control: every stage advances together
	logic           en;
	logic [LAT-1:0] v_q;

	assign en       = !v_q[LAT-1] || res.ready;
	assign pt.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-2:0], pt.valid};
	end

	// s1: center on the principal point
	logic signed [DW-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({{(DW-COORD_WIDTH){pt.point_x[COORD_WIDTH-1]}}, pt.point_x})
				- $signed({{(DW-FW){1'b0}}, cx});
			dy_s1 <= $signed({{(DW-COORD_WIDTH){pt.point_y[COORD_WIDTH-1]}}, pt.point_y})
				- $signed({{(DW-FW){1'b0}}, cy});
		end
	end

	// normalize
	ldpm_pkg::fix_sat_t dvx, dvy;
	ldpm_div #(.MW(DW-1)) u_div_x (.clk, .en, .d(dx_s1), .f(focal_x_q), .y(dvx));
	ldpm_div #(.MW(DW-1)) u_div_y (.clk, .en, .d(dy_s1), .f(focal_y_q), .y(dvy));

	// squares and cross term
	ldpm_pkg::fix_sat_t m_xx, m_yy, m_xy;
	logic               sd_d;
	ldpm_mul u_mul_xx (.clk, .en, .a(dvx.val), .b(dvx.val), .y(m_xx));
	ldpm_mul u_mul_yy (.clk, .en, .a(dvy.val), .b(dvy.val), .y(m_yy));
	ldpm_mul u_mul_xy (.clk, .en, .a(dvx.val), .b(dvy.val), .y(m_xy));
	ldpm_dly #(.W(1), .N(ML)) u_dly_sd (.clk, .en, .d(dvx.sat | dvy.sat), .q(sd_d));

	// s2: r^2, 2xy, 2x^2, 2y^2
	ldpm_pkg::fix_sat_t r2_c, xy2_c, xx2_c, yy2_c;
	ldpm_pkg::fix_t     r2_s2, xy2_s2, xx2_s2, yy2_s2;
	logic               sat_s2;

	always_comb begin
		r2_c  = ldpm_pkg::sadd(m_xx.val, m_yy.val);
		xy2_c = ldpm_pkg::sadd(m_xy.val, m_xy.val);
		xx2_c = ldpm_pkg::sadd(m_xx.val, m_xx.val);
		yy2_c = ldpm_pkg::sadd(m_yy.val, m_yy.val);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s2  <= r2_c.val;
			xy2_s2 <= xy2_c.val;
			xx2_s2 <= xx2_c.val;
			yy2_s2 <= yy2_c.val;
			sat_s2 <= sd_d | m_xx.sat | m_yy.sat | m_xy.sat | r2_c.sat | xy2_c.sat
				| xx2_c.sat | yy2_c.sat;
		end
	end

	// s3: r^2 + 2x^2, r^2 + 2y^2
	ldpm_pkg::fix_sat_t sx_c, sy_c;
	ldpm_pkg::fix_t     sx_s3, sy_s3, r2_s3, xy2_s3;
	logic               sat_s3;

	always_comb begin
		sx_c = ldpm_pkg::sadd(r2_s2, xx2_s2);
		sy_c = ldpm_pkg::sadd(r2_s2, yy2_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s3  <= sx_c.val;
			sy_s3  <= sy_c.val;
			r2_s3  <= r2_s2;
			xy2_s3 <= xy2_s2;
			sat_s3 <= sat_s2 | sx_c.sat | sy_c.sat;
		end
	end

	// r^4, k1 r^2 and tangential products
	ldpm_pkg::fix_sat_t m_r4, m_k1, m_tx1, m_tx2, m_ty1, m_ty2;
	logic [IW-1:0]      r2_d;
	logic               sat3_d;
	ldpm_mul u_mul_r4  (.clk, .en, .a(r2_s3), .b(r2_s3), .y(m_r4));
	ldpm_mul u_mul_k1  (.clk, .en, .a(k1), .b(r2_s3), .y(m_k1));
	ldpm_mul u_mul_tx1 (.clk, .en, .a(p1), .b(xy2_s3), .y(m_tx1));
	ldpm_mul u_mul_tx2 (.clk, .en, .a(p2), .b(sx_s3), .y(m_tx2));
	ldpm_mul u_mul_ty1 (.clk, .en, .a(p1), .b(sy_s3), .y(m_ty1));
	ldpm_mul u_mul_ty2 (.clk, .en, .a(p2), .b(xy2_s3), .y(m_ty2));
	ldpm_dly #(.W(IW), .N(ML)) u_dly_r2 (.clk, .en, .d(r2_s3), .q(r2_d));
	ldpm_dly #(.W(1), .N(ML)) u_dly_s3 (.clk, .en, .d(sat_s3), .q(sat3_d));

	// r^6 and k2 r^4
	ldpm_pkg::fix_sat_t m_r6, m_k2;
	ldpm_mul u_mul_r6 (.clk, .en, .a(m_r4.val), .b($signed(r2_d)), .y(m_r6));
	ldpm_mul u_mul_k2 (.clk, .en, .a(k2), .b(m_r4.val), .y(m_k2));

	// s4: 1 + k1 r^2, tangential sums
	ldpm_pkg::fix_sat_t rad1_c, tx_c, ty_c;
	ldpm_pkg::fix_t     rad1_s4, tx_s4, ty_s4;
	logic               sat_s4;

	always_comb begin
		rad1_c = ldpm_pkg::sadd(ldpm_pkg::ONE_Q, m_k1.val);
		tx_c   = ldpm_pkg::sadd(m_tx1.val, m_tx2.val);
		ty_c   = ldpm_pkg::sadd(m_ty1.val, m_ty2.val);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad1_s4 <= rad1_c.val;
			tx_s4   <= tx_c.val;
			ty_s4   <= ty_c.val;
			sat_s4  <= sat3_d | m_r4.sat | m_k1.sat | m_tx1.sat | m_tx2.sat | m_ty1.sat
				| m_ty2.sat | rad1_c.sat | tx_c.sat | ty_c.sat;
		end
	end

	logic [IW-1:0] rad1_d, tx_d, ty_d;
	logic          sat4_d;
	ldpm_dly #(.W(IW), .N(ML-1)) u_dly_rad1 (.clk, .en, .d(rad1_s4), .q(rad1_d));
	ldpm_dly #(.W(1), .N(ML-1)) u_dly_s4 (.clk, .en, .d(sat_s4), .q(sat4_d));
	ldpm_dly #(.W(IW), .N(3*ML)) u_dly_tx (.clk, .en, .d(tx_s4), .q(tx_d));
	ldpm_dly #(.W(IW), .N(3*ML)) u_dly_ty (.clk, .en, .d(ty_s4), .q(ty_d));

	// k3 r^6
	ldpm_pkg::fix_sat_t m_k3;
	ldpm_mul u_mul_k3 (.clk, .en, .a(k3), .b(m_r6.val), .y(m_k3));

	// s5: + k2 r^4
	ldpm_pkg::fix_sat_t rad2_c;
	ldpm_pkg::fix_t     rad2_s5;
	logic               sat_s5;

	assign rad2_c = ldpm_pkg::sadd($signed(rad1_d), m_k2.val);

	always_ff @(posedge clk) begin
		if (en) begin
			rad2_s5 <= rad2_c.val;
			sat_s5  <= sat4_d | m_r6.sat | m_k2.sat | rad2_c.sat;
		end
	end

	logic [IW-1:0] rad2_d;
	logic          sat5_d;
	ldpm_dly #(.W(IW), .N(ML-1)) u_dly_rad2 (.clk, .en, .d(rad2_s5), .q(rad2_d));
	ldpm_dly #(.W(1), .N(ML-1)) u_dly_s5 (.clk, .en, .d(sat_s5), .q(sat5_d));

	// s6: + k3 r^6
	ldpm_pkg::fix_sat_t rad_c;
	ldpm_pkg::fix_t     rad_s6;
	logic               sat_s6;

	assign rad_c = ldpm_pkg::sadd($signed(rad2_d), m_k3.val);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s6 <= rad_c.val;
			sat_s6 <= sat5_d | m_k3.sat | rad_c.sat;
		end
	end

	// radial scaling of the normalized point
	logic [IW-1:0]      x_d, y_d;
	logic               sat6_d;
	ldpm_pkg::fix_sat_t m_xd, m_yd;
	ldpm_dly #(.W(IW), .N(4*ML+3)) u_dly_x (.clk, .en, .d(dvx.val), .q(x_d));
	ldpm_dly #(.W(IW), .N(4*ML+3)) u_dly_y (.clk, .en, .d(dvy.val), .q(y_d));
	ldpm_mul u_mul_xd (.clk, .en, .a($signed(x_d)), .b(rad_s6), .y(m_xd));
	ldpm_mul u_mul_yd (.clk, .en, .a($signed(y_d)), .b(rad_s6), .y(m_yd));
	ldpm_dly #(.W(1), .N(ML)) u_dly_s6 (.clk, .en, .d(sat_s6), .q(sat6_d));

	// s7: add tangential terms
	ldpm_pkg::fix_sat_t xd_c, yd_c;
	ldpm_pkg::fix_t     xd_s7, yd_s7;
	logic               sat_s7;

	always_comb begin
		xd_c = ldpm_pkg::sadd(m_xd.val, $signed(tx_d));
		yd_c = ldpm_pkg::sadd(m_yd.val, $signed(ty_d));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xd_s7  <= xd_c.val;
			yd_s7  <= yd_c.val;
			sat_s7 <= sat6_d | m_xd.sat | m_yd.sat | xd_c.sat | yd_c.sat;
		end
	end

	// back to pixels
	ldpm_pkg::fix_sat_t m_px, m_py;
	logic               sat7_d;
	ldpm_mul u_mul_px (.clk, .en, .a(xd_s7), .b(fx), .y(m_px));
	ldpm_mul u_mul_py (.clk, .en, .a(yd_s7), .b(fy), .y(m_py));
	ldpm_dly #(.W(1), .N(ML)) u_dly_s7 (.clk, .en, .d(sat_s7), .q(sat7_d));

	// s8: add principal point, clip to the coordinate range
	logic signed [OSW-1:0]         ox, oy, oxc, oyc;
	logic                          ox_sat, oy_sat;
	logic signed [COORD_WIDTH-1:0] out_x_s8, out_y_s8;
	logic                          sat_s8;

	always_comb begin
		ox     = $signed({{2{m_px.val[IW-1]}}, m_px.val}) + $signed({{(OSW-FW){1'b0}}, cx});
		oy     = $signed({{2{m_py.val[IW-1]}}, m_py.val}) + $signed({{(OSW-FW){1'b0}}, cy});
		ox_sat = (ox > CMAX) || (ox < CMIN);
		oy_sat = (oy > CMAX) || (oy < CMIN);
		oxc    = (ox > CMAX) ? CMAX : ((ox < CMIN) ? CMIN : ox);
		oyc    = (oy > CMAX) ? CMAX : ((oy < CMIN) ? CMIN : oy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x_s8 <= oxc[COORD_WIDTH-1:0];
			out_y_s8 <= oyc[COORD_WIDTH-1:0];
			sat_s8   <= sat7_d | m_px.sat | m_py.sat | ox_sat | oy_sat;
		end
	end

	assign res.valid     = v_q[LAT-1];
	assign res.out_x     = out_x_s8;
	assign res.out_y     = out_y_s8;
	assign res.saturated = sat_s8;

	`ASSERT_NEXT(a_stall_freezes, clk, arst_n, !en, $stable(v_q))
	`ASSERT_NEXT(a_accept_enters, clk, arst_n, pt.valid && pt.ready, v_q[0])
	`ASSERT_IMPLIES(a_ready_drop_cause, clk, arst_n, !pt.ready, res.valid && !res.ready)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the lens distortion point mapper.
`timescale 1ns / 1ps

module tb_top;

	localparam int       CW        = 32;
	localparam longint   QLIM      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint   QONE      = 64'sh0000_0000_1000_0000;
	localparam int       DRAIN     = 100;
	localparam int       STALL_LEN = 400;
	localparam int       WD_LIMIT  = 5000;

	typedef struct {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] ox;
		logic signed [CW-1:0] oy;
		logic                 sat;
	} mapped_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	ldpm_pkg::cfg_idx_t   cfg_idx;
	logic [63:0]          cfg_data;

	ldpm_pt_if  #(.COORD_WIDTH(CW)) pt_bus ();
	ldpm_res_if #(.COORD_WIDTH(CW)) res_bus ();

	lens_distortion_point_map #(.COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.pt(pt_bus.sink),
		.res(res_bus.source)
	);

	// shadow copy of the configuration
	logic [31:0] fx_q, fy_q;
	logic [63:0] pp_q;
	logic [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

	point_t  points_to_send[$];
	mapped_t expected_maps[$];
	int      errors;
	bit      no_idle;
	bit      stall_req;
	bit      stall_done;
	int      stall_cnt;
	int      quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic longint clip_q(longint v, inout bit s);
		if (v > QLIM) begin
			s = 1'b1;
			return QLIM;
		end
		if (v < -QLIM) begin
			s = 1'b1;
			return -QLIM;
		end
		return v;
	endfunction

	// (a * b) >> 28, truncated toward zero, clipped
	function automatic longint mul_q(longint a, longint b, inout bit s);
		bit           neg;
		logic [63:0]  ma, mb;
		logic [127:0] p;
		longint       r;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = {64'd0, ma} * {64'd0, mb};
		p = p >> ldpm_pkg::FRAC;
		if (p > 128'(QLIM)) begin
			s = 1'b1;
			r = QLIM;
		end else begin
			r = longint'(p[63:0]);
		end
		return neg ? -r : r;
	endfunction

	// Q.16 numerator over unsigned Q16.16 focal, result Q.28
	function automatic longint div_q(longint d, logic [31:0] f, inout bit s);
		logic [63:0] m, fd, qi, q;
		m = (d < 0) ? -d : d;
		fd = (f == 0) ? 64'd1 : {32'd0, f};
		qi = m / fd;
		if (qi > (QLIM >> ldpm_pkg::FRAC)) begin
			s = 1'b1;
			q = QLIM;
		end else begin
			q = (qi << ldpm_pkg::FRAC) + (((m % fd) << ldpm_pkg::FRAC) / fd);
			if (q > QLIM) begin
				s = 1'b1;
				q = QLIM;
			end
		end
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [CW-1:0] to_pixel(longint v, inout bit s);
		longint hi, lo;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			s = 1'b1;
			v = hi;
		end
		if (v < lo) begin
			s = 1'b1;
			v = lo;
		end
		return v[CW-1:0];
	endfunction

	function automatic mapped_t map_point(point_t p);
		bit      s;
		longint  cx, cy, x, y, xx, yy, r2, r4, r6, rad, xd, yd, xy2, tx, ty;
		longint  k1, k2, k3, c1, c2;
		mapped_t m;
		s = 1'b0;
		cx = longint'({32'd0, pp_q[63:32]});
		cy = longint'({32'd0, pp_q[31:0]});
		k1 = longint'(signed'(k1_q));
		k2 = longint'(signed'(k2_q));
		k3 = longint'(signed'(k3_q));
		c1 = longint'(signed'(p1_q));
		c2 = longint'(signed'(p2_q));
		x = div_q(longint'(p.px) - cx, fx_q, s);
		y = div_q(longint'(p.py) - cy, fy_q, s);
		xx = mul_q(x, x, s);
		yy = mul_q(y, y, s);
		r2 = clip_q(xx + yy, s);
		r4 = mul_q(r2, r2, s);
		r6 = mul_q(r4, r2, s);
		rad = clip_q(QONE + mul_q(k1, r2, s), s);
		rad = clip_q(rad + mul_q(k2, r4, s), s);
		rad = clip_q(rad + mul_q(k3, r6, s), s);
		xd = mul_q(x, rad, s);
		yd = mul_q(y, rad, s);
		xy2 = mul_q(x, y, s);
		xy2 = clip_q(xy2 + xy2, s);
		tx = clip_q(mul_q(c1, xy2, s)
			+ mul_q(c2, clip_q(r2 + clip_q(xx + xx, s), s), s), s);
		ty = clip_q(mul_q(c1, clip_q(r2 + clip_q(yy + yy, s), s), s)
			+ mul_q(c2, xy2, s), s);
		xd = clip_q(xd + tx, s);
		yd = clip_q(yd + ty, s);
		m.ox = to_pixel(mul_q(xd, longint'({32'd0, fx_q}), s) + cx, s);
		m.oy = to_pixel(mul_q(yd, longint'({32'd0, fy_q}), s) + cy, s);
		m.sat = s;
		return m;
	endfunction

	// point sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_bus.valid <= 1'b0;
		end else begin
			if (pt_bus.valid && pt_bus.ready)
				expected_maps.insert(expected_maps.size(),
					map_point('{pt_bus.point_x, pt_bus.point_y}));
			if (!pt_bus.valid || pt_bus.ready) begin
				if (points_to_send.size() > 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
					point_t p;
					p = points_to_send.pop_front();
					pt_bus.point_x <= p.px;
					pt_bus.point_y <= p.py;
					pt_bus.valid <= 1'b1;
				end else begin
					pt_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_cnt <= 0;
			stall_done <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_maps.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer x=%h y=%h sat=%b", $time,
						res_bus.out_x, res_bus.out_y, res_bus.saturated);
				end else begin
					mapped_t e;
					e = expected_maps.pop_front();
					if (res_bus.out_x !== e.ox) begin
						errors++;
						$display("%0t: out_x expected %h actual %h", $time, e.ox, res_bus.out_x);
					end
					if (res_bus.out_y !== e.oy) begin
						errors++;
						$display("%0t: out_y expected %h actual %h", $time, e.oy, res_bus.out_y);
					end
					if (res_bus.saturated !== e.sat) begin
						errors++;
						$display("%0t: saturated expected %b actual %b", $time, e.sat,
							res_bus.saturated);
					end
				end
			end
			if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				res_bus.ready <= 1'b0;
			end else if (stall_req && !stall_done) begin
				stall_cnt <= STALL_LEN;
				stall_done <= 1'b1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= no_idle || $urandom_range(0, 99) >= 28;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(ldpm_pkg::cfg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			ldpm_pkg::CFG_FOCAL_X: fx_q = val[31:0];
			ldpm_pkg::CFG_FOCAL_Y: fy_q = val[31:0];
			ldpm_pkg::CFG_PP:      pp_q = val;
			ldpm_pkg::CFG_K1:      k1_q = val[31:0];
			ldpm_pkg::CFG_K2:      k2_q = val[31:0];
			ldpm_pkg::CFG_K3:      k3_q = val[31:0];
			ldpm_pkg::CFG_P1:      p1_q = val[31:0];
			ldpm_pkg::CFG_P2:      p2_q = val[31:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] fx, logic [31:0] fy, logic [63:0] pp,
			logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
			logic [31:0] p1, logic [31:0] p2);
		// upper bits of the 32-bit registers carry junk to check masking
		write_reg(ldpm_pkg::CFG_FOCAL_X, {$urandom, fx});
		write_reg(ldpm_pkg::CFG_FOCAL_Y, {$urandom, fy});
		write_reg(ldpm_pkg::CFG_PP, pp);
		write_reg(ldpm_pkg::CFG_K1, {$urandom, k1});
		write_reg(ldpm_pkg::CFG_K2, {$urandom, k2});
		write_reg(ldpm_pkg::CFG_K3, {$urandom, k3});
		write_reg(ldpm_pkg::CFG_P1, {$urandom, p1});
		write_reg(ldpm_pkg::CFG_P2, {$urandom, p2});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (points_to_send.size() == 0 && !pt_bus.valid && expected_maps.size() == 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [31:0] small_coef(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic add_point(logic [31:0] x, logic [31:0] y);
		points_to_send.insert(points_to_send.size(), '{x, y});
	endtask

	// mostly image-sized points, some full-range noise
	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 80)
				add_point($urandom_range(0, 32'h0780_0000), $urandom_range(0, 32'h0438_0000));
			else
				add_point($urandom, $urandom);
		end
	endtask

	task automatic realistic_cfg();
		logic [31:0] f;
		f = $urandom_range(32'h0190_0000, 32'h05DC_0000);
		write_all(f, f + $urandom_range(0, 32'h0010_0000),
			{32'($urandom_range(32'h0200_0000, 32'h0500_0000)),
			 32'($urandom_range(32'h0100_0000, 32'h0300_0000))},
			small_coef(100_000_000), small_coef(30_000_000), small_coef(10_000_000),
			small_coef(1_000_000), small_coef(1_000_000));
	endtask

	initial begin
		errors = 0;
		no_idle = 1'b0;
		stall_req = 1'b0;
		quiet_cycles = 0;
		cfg_we = 1'b0;
		cfg_idx = ldpm_pkg::CFG_FOCAL_X;
		cfg_data = '0;
		pt_bus.valid = 1'b0;
		pt_bus.point_x = '0;
		pt_bus.point_y = '0;
		res_bus.ready = 1'b0;
		fx_q = 32'd65536000;
		fy_q = 32'd65536000;
		pp_q = '0;
		{k1_q, k2_q, k3_q, p1_q, p2_q} = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration, field extremes
		add_point(32'h0, 32'h0);
		add_point(32'h8000_0000, 32'h8000_0000);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'h7FFF_FFFF);
		add_point(32'h7FFF_FFFF, 32'h8000_0000);
		add_point(32'h0000_0001, 32'hFFFF_FFFF);
		add_point(32'h0280_0000, 32'h01E0_0000);
		drain();

		// large coefficients push intermediates and outputs into clipping
		write_all(32'h03E8_0000, 32'h03E8_0000, {32'h0280_0000, 32'h01E0_0000},
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		add_point(32'h0280_0000, 32'h01E0_0000);
		add_point(32'h0500_0000, 32'h03C0_0000);
		add_point(32'h7FFF_FFFF, 32'h8000_0000);
		add_point(32'h0290_0000, 32'h01D0_0000);
		drain();

		// zero focal lengths act as one lsb; principal point at maximum
		write_all(32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		add_point(32'h0, 32'h0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_point(32'h8000_0000, 32'hFFFF_FFFF);
		add_random(60);
		drain();

		// largest focal lengths, tiny distortion
		write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 32'h1, 32'hFFFF_FFFF, 32'h0,
			32'h1, 32'hFFFF_FFFF);
		add_point(32'h7FFF_FFFF, 32'h8000_0000);
		add_point(32'h8000_0000, 32'h7FFF_FFFF);
		add_random(60);
		drain();

		// realistic camera, long receiver hold-off so the pipe backs up
		realistic_cfg();
		add_random(200);
		stall_req = 1'b1;
		drain();

		// no idling on either side
		realistic_cfg();
		no_idle = 1'b1;
		add_random(200);
		drain();
		no_idle = 1'b0;

		write_all(32'h0001_0000, 32'h0000_0001, {$urandom, $urandom},
			small_coef(500_000_000), small_coef(500_000_000), small_coef(500_000_000),
			small_coef(50_000_000), small_coef(50_000_000));
		add_random(160);
		drain();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
